// ===== sv/bam_pkg.sv =====
// ---------------------------------------------------------------------------
// bam_pkg: shared types and constants for the bit-addressed memory
// Word layouts for the request and response channels, field widths,
// register reset values and register index codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bam_pkg;

  // field widths
  localparam int ADDR_W  = 19;
  localparam int WIDTH_W = 7;
  localparam int DATA_W  = 64;
  localparam int CFG_W   = 20;
  localparam int IDX_W   = 1;

  // default store size in 64-bit words
  localparam int WORD_COUNT_DEFAULT = 8192;

  // register reset values
  localparam logic [CFG_W-1:0] MEMORY_BITS_RESET = 20'h80000;
  localparam logic [CFG_W-1:0] VIDEO_BASE_RESET  = 20'h10000;

  // register index codes
  localparam logic [IDX_W-1:0] CFG_MEMORY_BITS = 1'b0;
  localparam logic [IDX_W-1:0] CFG_VIDEO_BASE  = 1'b1;

  // operation codes
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // request word
  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] bit_address;
    logic [WIDTH_W-1:0] field_width;
    logic [DATA_W-1:0] write_value;
  } in_word_t;

  // response word
  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              out_of_bounds;
    logic              video_touched;
  } out_word_t;

endpackage

// ===== sv/bit_addressed_memory_access.sv =====
// ---------------------------------------------------------------------------
// bit_addressed_memory_access: bit-addressed field read/write over 64-bit words
// A rejected or zero-width word goes from S_CHECK straight to S_DONE; a read
// passes S_RD1 and S_RD2, a write then S_WR0, and S_WR1 when the field
// straddles two words. A new word is taken only in S_IDLE, once the last
// response is taken; the single-port store and one 128-bit shifter are shared.
// Reset: registers return to their reset values and a clearing pass zeroes
// the store, one word a cycle, with in_ready low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_addressed_memory_access #(
  parameter int WORD_COUNT = bam_pkg::WORD_COUNT_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [bam_pkg::IDX_W-1:0] cfg_index,
  input  logic [bam_pkg::CFG_W-1:0] cfg_data,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bam_pkg::in_word_t         in_data,
  // response channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output bam_pkg::out_word_t        out_data
);

  import bam_pkg::*;

  localparam int AW = $clog2(WORD_COUNT);
  localparam logic [31:0] STORE_BITS = 32'(WORD_COUNT * 64);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RD1   = 3'd3;
  localparam logic [2:0] S_RD2   = 3'd4;
  localparam logic [2:0] S_WR0   = 3'd5;
  localparam logic [2:0] S_WR1   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [AW-1:0]     clr_idx;
  logic [CFG_W-1:0]  memory_bits;
  logic [CFG_W-1:0]  video_base;

  // item and working registers
  in_word_t          item;
  logic [6:0]        sh_amt;
  logic              straddle;
  logic [127:0]      mask;
  logic [127:0]      mask_sh;
  logic [127:0]      data_sh;
  logic [63:0]       w0;
  logic [127:0]      pair;
  out_word_t         result;

  // store
  logic [63:0]       store [WORD_COUNT];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [63:0]       mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [63:0]       mem_rdata;

  // address arithmetic
  logic [CFG_W-1:0]  end_addr;
  logic              oob_c;
  logic              go_c;
  logic [7:0]        right_c;
  logic [7:0]        sh_c;
  logic [AW-1:0]     word_idx;
  logic [AW-1:0]     word_idx1;
  logic [127:0]      merged;

  // shared shifter
  logic              shf_right;
  logic [6:0]        shf_amt;
  logic [127:0]      shf_in;
  logic [127:0]      shf_out;

  // end of field and bounds check
  assign end_addr  = {1'b0, item.bit_address} + {13'b0, item.field_width};
  assign oob_c     = (item.field_width > 7'd64) || (end_addr > memory_bits) ||
                     ({12'b0, end_addr} > STORE_BITS);
  assign go_c      = !oob_c && (item.field_width != '0);
  assign right_c   = {2'b0, item.bit_address[5:0]} + {1'b0, item.field_width};
  assign sh_c      = 8'd128 - right_c;
  assign word_idx  = AW'(item.bit_address[ADDR_W-1:6]);
  assign word_idx1 = AW'(word_idx + 1'b1);
  assign merged    = (pair & ~mask_sh) | data_sh;

  // shifter operand selection
  always_comb begin
    shf_right = 1'b0;
    shf_amt   = '0;
    shf_in    = '0;
    unique case (state)
      S_CHECK: begin
        shf_in  = '1;
        shf_amt = item.field_width;
      end
      S_RD1: begin
        shf_in  = mask;
        shf_amt = sh_amt;
      end
      S_RD2: begin
        shf_amt = sh_amt;
        if (item.func == FUNC_WRITE) begin
          shf_in = {64'b0, item.write_value & mask[63:0]};
        end else begin
          shf_right = 1'b1;
          shf_in    = {w0, mem_rdata} & mask_sh;
        end
      end
      S_CLEAR, S_IDLE, S_WR0, S_WR1, S_DONE: begin
        shf_in = '0;
      end
    endcase
  end

  assign shf_out = shf_right ? (shf_in >> shf_amt) : (shf_in << shf_amt);

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_idx;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = word_idx;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      S_CHECK: begin
        mem_re = go_c;
      end
      S_RD1: begin
        mem_re    = straddle;
        mem_raddr = word_idx1;
      end
      S_WR0: begin
        mem_we    = 1'b1;
        mem_wdata = merged[127:64];
      end
      S_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = word_idx1;
        mem_wdata = pair[63:0];
      end
      S_IDLE, S_RD2, S_DONE: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // store array, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= store[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_idx == LAST_WORD) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_CHECK;
      S_CHECK: state_next = go_c ? S_RD1 : S_DONE;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = (item.func == FUNC_WRITE) ? S_WR0 : S_DONE;
      S_WR0:   state_next = straddle ? S_WR1 : S_DONE;
      S_WR1:   state_next = S_DONE;
      S_DONE:  if (out_ready) state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      memory_bits <= MEMORY_BITS_RESET;
      video_base  <= VIDEO_BASE_RESET;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= AW'(clr_idx + 1'b1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MEMORY_BITS: memory_bits <= cfg_data;
          CFG_VIDEO_BASE:  video_base  <= cfg_data;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) item <= in_data;
      end
      S_CHECK: begin
        sh_amt                 <= sh_c[6:0];
        straddle               <= right_c > 8'd64;
        mask                   <= ~shf_out;
        result.read_value      <= '0;
        result.out_of_bounds   <= oob_c;
        result.video_touched   <= go_c && (item.func == FUNC_WRITE) &&
                                  (end_addr > video_base);
      end
      S_RD1: begin
        w0      <= mem_rdata;
        mask_sh <= shf_out;
      end
      S_RD2: begin
        pair <= {w0, mem_rdata};
        if (item.func == FUNC_WRITE) begin
          data_sh <= shf_out;
        end else begin
          result.read_value <= shf_out[63:0];
        end
      end
      S_WR0: begin
        pair <= merged;
      end
      S_CLEAR, S_WR1, S_DONE: begin
        w0 <= w0;
      end
    endcase
  end

  // handshakes
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign out_data  = result;

endmodule

// ===== tb/sv/bam_field_checker.sv =====
// ---------------------------------------------------------------------------
// bam_field_checker: response checker for the bit-addressed memory
// Watches the register port and both channels, keeps a shadow copy of the
// word store and the registers, predicts the response of every accepted
// request word and compares it field by field with the responses in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bam_field_checker #(
  parameter int WORD_COUNT = bam_pkg::WORD_COUNT_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bam_pkg::IDX_W-1:0] cfg_index,
  input  logic [bam_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  bam_pkg::in_word_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  bam_pkg::out_word_t        out_data,
  output int                        mismatch_count,
  output int                        pending
);

  import bam_pkg::*;

  localparam int unsigned STORE_BITS = WORD_COUNT * 64;
  localparam int          REPORT_MAX = 10;
  localparam int          AW         = $clog2(WORD_COUNT);

  // shadow store and registers
  logic [DATA_W-1:0] shadow_words [WORD_COUNT];
  int unsigned       mem_bits;
  int unsigned       vid_base;

  // responses still owed by the block, oldest first
  out_word_t         expected_responses [$];
  out_word_t         want;
  out_word_t         got;
  int                fail_total;

  // work out the response of one access and apply a write to the shadow store
  task automatic predict_field_access(input in_word_t req, output out_word_t resp);
    int unsigned  addr;
    int unsigned  n;
    int unsigned  bound;
    logic [AW-1:0] idx;
    logic [AW-1:0] idx1;
    int unsigned  off;
    int unsigned  sh;
    logic [127:0] pair;
    logic [127:0] low_ones;
    logic [127:0] field_mask;
    logic [127:0] wdata;
    resp  = '0;
    addr  = 32'(req.bit_address);
    n     = 32'(req.field_width);
    bound = (mem_bits > STORE_BITS) ? STORE_BITS : mem_bits;
    if (n > 64 || addr + n > bound) begin
      resp.out_of_bounds = 1'b1;
    end else if (n != 0) begin
      idx        = AW'(addr >> 6);
      idx1       = AW'(idx + 1'b1);
      off        = addr & 63;
      sh         = 128 - off - n;
      // the field sits in the top word and, when it straddles, the next one
      pair       = {shadow_words[idx], (off + n > 64) ? shadow_words[idx1] : 64'h0};
      low_ones   = (128'h1 << n) - 128'h1;
      field_mask = low_ones << sh;
      if (req.func == FUNC_READ) begin
        resp.read_value = DATA_W'((pair & field_mask) >> sh);
      end else begin
        wdata = {64'h0, req.write_value} & low_ones;
        pair  = (pair & ~field_mask) | (wdata << sh);
        shadow_words[idx] = pair[127:64];
        if (off + n > 64) shadow_words[idx1] = pair[63:0];
        if (addr + n > vid_base) resp.video_touched = 1'b1;
      end
    end
  endtask

  // track registers, check responses, then queue predictions
  always @(posedge clk) begin
    if (rst) begin
      shadow_words = '{default: '0};
      mem_bits = 32'(MEMORY_BITS_RESET);
      vid_base = 32'(VIDEO_BASE_RESET);
      expected_responses.delete();
      fail_total = 0;
      mismatch_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEMORY_BITS: mem_bits = 32'(cfg_data);
          CFG_VIDEO_BASE:  vid_base = 32'(cfg_data);
          default: ;
        endcase
      end

      // response word taken by the receiver
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_responses.size() == 0) begin
          if (fail_total < REPORT_MAX)
            $display("%0t: response with nothing outstanding: value %h oob %b vid %b",
                     $time, got.read_value, got.out_of_bounds, got.video_touched);
          fail_total++;
        end else begin
          want = expected_responses.pop_front();
          if (got.read_value !== want.read_value ||
              got.out_of_bounds !== want.out_of_bounds ||
              got.video_touched !== want.video_touched) begin
            if (fail_total < REPORT_MAX)
              $display("%0t: mismatch: expected value %h oob %b vid %b, %s %h oob %b vid %b",
                       $time, want.read_value, want.out_of_bounds, want.video_touched,
                       "got value", got.read_value, got.out_of_bounds, got.video_touched);
            fail_total++;
          end
        end
      end

      // request word accepted by the block
      if (in_valid && in_ready) begin
        predict_field_access(in_data, want);
        expected_responses.push_back(want);
      end

      mismatch_count <= fail_total;
      pending <= expected_responses.size();
    end
  end

endmodule

// ===== tb/sv/tb_bit_addressed_memory_access.sv =====
// ---------------------------------------------------------------------------
// tb_bit_addressed_memory_access: testbench for the bit-addressed memory
// Runs directed field accesses at the edges of words, store and video
// region, then random reads and writes under several register settings,
// with random gaps on the request side and random stalls on the response
// side. Checking is done by bam_field_checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bit_addressed_memory_access;

  import bam_pkg::*;

  localparam int          RESET_CYCLES  = 8;
  localparam int          DRAIN_CYCLES  = 12;
  localparam int          IDLE_LIMIT    = 60000;
  localparam int          ITEMS_PER_SET = 170;
  localparam int          SET_COUNT     = 7;
  localparam int unsigned STORE_BITS    = WORD_COUNT_DEFAULT * 64;
  localparam int unsigned ADDR_MAX      = (1 << ADDR_W) - 1;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [IDX_W-1:0]   cfg_index = CFG_MEMORY_BITS;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_word_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_data;

  int                 mismatch_count;
  int                 pending;
  int                 idle_cycles;
  int                 stall_left;
  int                 stall_draw;
  bit                 burst;
  int unsigned        cur_mem_bits  = 32'(MEMORY_BITS_RESET);
  int unsigned        cur_video_base = 32'(VIDEO_BASE_RESET);

  always #6 clk = ~clk;

  bit_addressed_memory_access DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bam_field_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // receiver: random stall before each response word, none during bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      stall_draw = burst ? 0 : $urandom_range(0, 6);
      stall_left <= stall_draw;
      out_ready  <= (stall_draw == 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one request word after a random gap and wait for acceptance
  task automatic send_word(input in_word_t w);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic access(input logic f, input int unsigned a, input int unsigned n,
                        input logic [DATA_W-1:0] v);
    in_word_t w;
    w.func        = f;
    w.bit_address = a[ADDR_W-1:0];
    w.field_width = n[WIDTH_W-1:0];
    w.write_value = v;
    send_word(w);
  endtask

  // let every response arrive, then leave the block time to settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write both registers on consecutive edges
  task automatic set_config(input int unsigned mem, input int unsigned vid);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MEMORY_BITS;
    cfg_data  <= mem[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_VIDEO_BASE;
    cfg_data  <= vid[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mem_bits   = mem & 32'hFFFFF;
    cur_video_base = vid & 32'hFFFFF;
  endtask

  // addresses biased to a small hot area, word edges, the bound and video base
  function automatic int unsigned pick_address();
    int unsigned a;
    int unsigned lim;
    lim = (cur_mem_bits > STORE_BITS) ? STORE_BITS : cur_mem_bits;
    case ($urandom_range(0, 10))
      0, 1, 2, 3: a = $urandom_range(0, 1023);
      4, 5:       a = $urandom_range(1, WORD_COUNT_DEFAULT - 1) * 64 - $urandom_range(0, 64);
      6, 7:       a = $urandom_range(0, ADDR_MAX);
      8, 9:       a = (lim > 80) ? lim - $urandom_range(0, 80) : $urandom_range(0, 80);
      default:    a = (cur_video_base > 64) ? cur_video_base - $urandom_range(0, 64)
                                            : $urandom_range(0, 64);
    endcase
    if (a > ADDR_MAX) a = ADDR_MAX;
    return a;
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 9))
      6:       return 64;
      7:       return 0;
      8:       return $urandom_range(65, 127);
      9:       return $urandom_range(0, 8);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  initial begin
    burst = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int set = 0; set < SET_COUNT; set++) begin
      // register settings, reset values first
      case (set)
        0: ;
        1: set_config(32'hFFFFF, 0);
        2: set_config(0, 32'hFFFFF);
        3: begin
          cur_mem_bits = $urandom_range(1, STORE_BITS);
          set_config(cur_mem_bits, $urandom_range(0, cur_mem_bits));
        end
        4: set_config(STORE_BITS, STORE_BITS);
        5: set_config(4096, 2048);
        default: set_config(32'(MEMORY_BITS_RESET), 32'(VIDEO_BASE_RESET));
      endcase

      // directed accesses at word, store and video edges
      if (set == 0) begin
        access(FUNC_WRITE, 0, 64, 64'h0123_4567_89AB_CDEF);
        access(FUNC_READ,  0, 64, 64'hFFFF_FFFF_FFFF_FFFF);
        access(FUNC_WRITE, 60, 64, 64'hFFFF_FFFF_FFFF_FFFF);
        access(FUNC_READ,  56, 64, '0);
        access(FUNC_READ,  0, 1, '0);
        access(FUNC_WRITE, 127, 1, 64'hFFFF_FFFF_FFFF_FFFE);
        access(FUNC_READ,  64, 64, '0);
        access(FUNC_WRITE, 200, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        access(FUNC_READ,  192, 16, '0);
        access(FUNC_READ,  ADDR_MAX, 0, '0);
        access(FUNC_WRITE, ADDR_MAX, 1, 64'h1);
        access(FUNC_READ,  ADDR_MAX, 1, '0);
        access(FUNC_READ,  ADDR_MAX, 2, '0);
        access(FUNC_READ,  STORE_BITS - 64, 64, '0);
        access(FUNC_WRITE, STORE_BITS - 63, 64, 64'hA5A5_A5A5_A5A5_A5A5);
        access(FUNC_READ,  0, 65, '0);
        access(FUNC_WRITE, 0, 127, 64'hFFFF_FFFF_FFFF_FFFF);
        access(FUNC_WRITE, 32'(VIDEO_BASE_RESET) - 1, 1, 64'h1);
        access(FUNC_WRITE, 32'(VIDEO_BASE_RESET) - 1, 2, 64'h2);
        access(FUNC_READ,  32'(VIDEO_BASE_RESET) - 1, 2, '0);
        access(FUNC_WRITE, 32'(VIDEO_BASE_RESET) - 64, 64, 64'hDEAD_BEEF_CAFE_F00D);
        access(FUNC_READ,  32'(VIDEO_BASE_RESET) - 64, 64, '0);
        access(FUNC_WRITE, 1, 63, 64'hFFFF_FFFF_FFFF_FFFF);
        access(FUNC_READ,  0, 64, '0);
      end

      // random accesses with random content
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        access(1'($urandom_range(0, 1)), pick_address(), pick_width(),
               {$urandom, $urandom});
      end
      burst = 1'b0;
      drain();
    end

    if (mismatch_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
